// ===== src/sparse_polynomial_adder_macros.svh =====
// Assertion macros used by the spa_ctrl RTL file.
`ifndef SPARSE_POLYNOMIAL_ADDER_MACROS_SVH
`define SPARSE_POLYNOMIAL_ADDER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SPA_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SPA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/spa_pkg.sv =====
package spa_pkg;

  localparam int EXP_W  = 10;
  localparam int COEF_W = 32;
  localparam int TERM_W = EXP_W + COEF_W;

  localparam logic [1:0] ACT_INSERT_A = 2'd0;
  localparam logic [1:0] ACT_INSERT_B = 2'd1;
  localparam logic [1:0] ACT_SUM      = 2'd2;
  localparam logic [1:0] ACT_CLEAR    = 2'd3;

  localparam logic [1:0] ST_TERM  = 2'd0;
  localparam logic [1:0] ST_OK    = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;
  localparam logic [1:0] ST_EMPTY = 2'd3;

  typedef struct packed {
    logic [EXP_W-1:0]         exponent;
    logic signed [COEF_W-1:0] coefficient;
  } term_t;

  typedef struct packed {
    logic                     push;
    logic [1:0]               status;
    logic [EXP_W-1:0]         exponent;
    logic signed [COEF_W-1:0] coefficient;
    logic                     last;
  } result_t;

endpackage

// ===== src/spa_ram.sv =====
module spa_ram #(
  parameter int WIDTH = 42,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== src/spa_ctrl.sv =====
`include "sparse_polynomial_adder_macros.svh"

module spa_ctrl #(
  parameter int MAX_TERMS = 16
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [1:0]                            action,
  input  logic [spa_pkg::EXP_W-1:0]             exponent,
  input  logic signed [spa_pkg::COEF_W-1:0]     coefficient,
  input  logic                                  room,
  output spa_pkg::result_t                      res,
  output logic                                  we_a,
  output logic                                  we_b,
  output logic [$clog2(MAX_TERMS)-1:0]          waddr,
  output spa_pkg::term_t                        wdata,
  output logic                                  re_a,
  output logic [$clog2(MAX_TERMS)-1:0]          raddr_a,
  input  logic [spa_pkg::TERM_W-1:0]            rdata_a,
  output logic                                  re_b,
  output logic [$clog2(MAX_TERMS)-1:0]          raddr_b,
  input  logic [spa_pkg::TERM_W-1:0]            rdata_b
);

  localparam int IW = $clog2(MAX_TERMS);
  localparam int CW = $clog2(MAX_TERMS + 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(MAX_TERMS);

  typedef enum logic [2:0] {S_IDLE, S_SHIFT, S_PLACE, S_MERGE, S_REPLY} state_t;

  state_t                            state;
  logic                              sel_b;
  logic [spa_pkg::EXP_W-1:0]         req_exp;
  logic signed [spa_pkg::COEF_W-1:0] req_coef;
  logic [IW-1:0]                     idx;
  logic [CW-1:0]                     count_a;
  logic [CW-1:0]                     count_b;
  logic [CW-1:0]                     ia;
  logic [CW-1:0]                     ib;
  logic [1:0]                        res_status;

  spa_pkg::term_t head_a;
  spa_pkg::term_t head_b;
  spa_pkg::term_t cur;
  spa_pkg::term_t new_term;
  logic [CW-1:0]  in_cnt;
  logic [CW-1:0]  ia_next;
  logic [CW-1:0]  ib_next;
  logic           a_has;
  logic           b_has;
  logic           take_a;
  logic           take_b;
  logic           merge_last;
  logic           we_sel;

  assign head_a   = spa_pkg::term_t'(rdata_a);
  assign head_b   = spa_pkg::term_t'(rdata_b);
  assign cur      = sel_b ? head_b : head_a;
  assign new_term = '{exponent: req_exp, coefficient: req_coef};
  assign in_cnt   = (action == spa_pkg::ACT_INSERT_B) ? count_b : count_a;
  assign in_ready = (state == S_IDLE);

  assign a_has  = (ia < count_a);
  assign b_has  = (ib < count_b);
  assign take_a = a_has && (!b_has || (head_a.exponent >= head_b.exponent));
  assign take_b = b_has && (!a_has || (head_b.exponent >= head_a.exponent));
  assign ia_next    = take_a ? ia + CW'(1) : ia;
  assign ib_next    = take_b ? ib + CW'(1) : ib;
  assign merge_last = (ia_next >= count_a) && (ib_next >= count_b);

  assign we_a = we_sel && !sel_b;
  assign we_b = we_sel && sel_b;

  always_comb begin
    we_sel  = 1'b0;
    waddr   = '0;
    wdata   = new_term;
    re_a    = 1'b0;
    re_b    = 1'b0;
    raddr_a = '0;
    raddr_b = '0;
    res     = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          if ((action == spa_pkg::ACT_INSERT_A || action == spa_pkg::ACT_INSERT_B) &&
              in_cnt != '0 && in_cnt != FULL_CNT) begin
            re_a    = (action == spa_pkg::ACT_INSERT_A);
            re_b    = (action == spa_pkg::ACT_INSERT_B);
            raddr_a = IW'(in_cnt - CW'(1));
            raddr_b = IW'(in_cnt - CW'(1));
          end else if (action == spa_pkg::ACT_SUM) begin
            re_a = (count_a != '0);
            re_b = (count_b != '0);
          end
        end
      end
      S_SHIFT: begin
        we_sel = 1'b1;
        waddr  = idx + IW'(1);
        if (cur.exponent <= req_exp) begin
          wdata = cur;
          if (idx != '0) begin
            re_a    = !sel_b;
            re_b    = sel_b;
            raddr_a = idx - IW'(1);
            raddr_b = idx - IW'(1);
          end
        end
      end
      S_PLACE: begin
        we_sel = 1'b1;
      end
      S_MERGE: begin
        if (room) begin
          re_a    = take_a && (ia_next < count_a);
          re_b    = take_b && (ib_next < count_b);
          raddr_a = IW'(ia_next);
          raddr_b = IW'(ib_next);
          res.push     = 1'b1;
          res.status   = spa_pkg::ST_TERM;
          res.exponent = take_a ? head_a.exponent : head_b.exponent;
          res.coefficient = (take_a ? head_a.coefficient : '0) +
                            (take_b ? head_b.coefficient : '0);
          res.last     = merge_last;
        end
      end
      S_REPLY: begin
        res.push   = room;
        res.status = res_status;
        res.last   = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      count_a    <= '0;
      count_b    <= '0;
      ia         <= '0;
      ib         <= '0;
      idx        <= '0;
      sel_b      <= 1'b0;
      res_status <= spa_pkg::ST_OK;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            req_exp  <= exponent;
            req_coef <= coefficient;
            sel_b    <= (action == spa_pkg::ACT_INSERT_B);
            case (action)
              spa_pkg::ACT_INSERT_A, spa_pkg::ACT_INSERT_B: begin
                if (in_cnt == FULL_CNT) begin
                  res_status <= spa_pkg::ST_FULL;
                  state      <= S_REPLY;
                end else if (in_cnt == '0) begin
                  state <= S_PLACE;
                end else begin
                  idx   <= IW'(in_cnt - CW'(1));
                  state <= S_SHIFT;
                end
              end
              spa_pkg::ACT_SUM: begin
                ia <= '0;
                ib <= '0;
                if (count_a == '0 && count_b == '0) begin
                  res_status <= spa_pkg::ST_EMPTY;
                  state      <= S_REPLY;
                end else begin
                  state <= S_MERGE;
                end
              end
              default: begin
                count_a    <= '0;
                count_b    <= '0;
                res_status <= spa_pkg::ST_OK;
                state      <= S_REPLY;
              end
            endcase
          end
        end
        S_SHIFT: begin
          if (cur.exponent > req_exp) begin
            if (sel_b) begin
              count_b <= count_b + CW'(1);
            end else begin
              count_a <= count_a + CW'(1);
            end
            res_status <= spa_pkg::ST_OK;
            state      <= S_REPLY;
          end else if (idx == '0) begin
            state <= S_PLACE;
          end else begin
            idx <= idx - IW'(1);
          end
        end
        S_PLACE: begin
          if (sel_b) begin
            count_b <= count_b + CW'(1);
          end else begin
            count_a <= count_a + CW'(1);
          end
          res_status <= spa_pkg::ST_OK;
          state      <= S_REPLY;
        end
        S_MERGE: begin
          if (room) begin
            ia <= ia_next;
            ib <= ib_next;
            if (merge_last) begin
              state <= S_IDLE;
            end
          end
        end
        S_REPLY: begin
          if (room) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `SPA_ASSERT_SAME(a_push_room, clk, rst, res.push, room, "Result pushed without room.")
  `SPA_ASSERT_SAME(a_merge_has_term, clk, rst, state == S_MERGE, a_has || b_has, "Merge with both stores exhausted.")
  `SPA_ASSERT_NEXT(a_place_count, clk, rst, state == S_PLACE && !sel_b, count_a == $past(count_a) + CW'(1), "Insert did not grow store A.")
  `SPA_ASSERT_NEXT(a_merge_done, clk, rst, state == S_MERGE && res.push && res.last, state == S_IDLE, "Merge did not end after its last term.")

endmodule

// ===== src/sparse_polynomial_adder.sv =====
// Sparse polynomial adder with two term stores, A and B, kept in descending exponent order.
// Input channel (in_valid/in_ready) carries one request: insert into A, insert into B,
// sum, or clear. Output channel (out_valid/out_ready) returns results; last marks the
// final result of a request.
// Only one request is in progress at a time; in_ready is high while the block is idle.
// An insert into a store holding n terms walks from the tail toward the insertion point,
// moving one entry per cycle through the store memory.
// A refused insert (store full), a clear and a sum of two empty stores go straight to the reply.
// A sum reads the heads of the non-empty store memories in the cycle its request is
// accepted and then emits one term per cycle while the output register has room.
// Results leave through an output register; a stalled receiver holds the sequencer
// until the register is free, and the next request is taken once the last result
// of the current one is registered.
// Reset empties both stores and clears out_valid; store contents are not
// cleared and no initialization pass is needed.
module sparse_polynomial_adder #(
  parameter int MAX_TERMS = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [1:0]                        action,
  input  logic [spa_pkg::EXP_W-1:0]         exponent,
  input  logic signed [spa_pkg::COEF_W-1:0] coefficient,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [1:0]                        status,
  output logic [spa_pkg::EXP_W-1:0]         term_exponent,
  output logic signed [spa_pkg::COEF_W-1:0] term_coefficient,
  output logic                              last
);

  localparam int IW = $clog2(MAX_TERMS);

  spa_pkg::result_t            res;
  spa_pkg::term_t              wdata;
  logic                        room;
  logic                        we_a;
  logic                        we_b;
  logic [IW-1:0]               waddr;
  logic                        re_a;
  logic                        re_b;
  logic [IW-1:0]               raddr_a;
  logic [IW-1:0]               raddr_b;
  logic [spa_pkg::TERM_W-1:0]  rdata_a;
  logic [spa_pkg::TERM_W-1:0]  rdata_b;

  assign room = !out_valid || out_ready;

  spa_ctrl #(
    .MAX_TERMS(MAX_TERMS)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .action     (action),
    .exponent   (exponent),
    .coefficient(coefficient),
    .room       (room),
    .res        (res),
    .we_a       (we_a),
    .we_b       (we_b),
    .waddr      (waddr),
    .wdata      (wdata),
    .re_a       (re_a),
    .raddr_a    (raddr_a),
    .rdata_a    (rdata_a),
    .re_b       (re_b),
    .raddr_b    (raddr_b),
    .rdata_b    (rdata_b)
  );

  spa_ram #(
    .WIDTH(spa_pkg::TERM_W),
    .DEPTH(MAX_TERMS)
  ) u_ram_a (
    .clk  (clk),
    .we   (we_a),
    .waddr(waddr),
    .wdata(wdata),
    .re   (re_a),
    .raddr(raddr_a),
    .rdata(rdata_a)
  );

  spa_ram #(
    .WIDTH(spa_pkg::TERM_W),
    .DEPTH(MAX_TERMS)
  ) u_ram_b (
    .clk  (clk),
    .we   (we_b),
    .waddr(waddr),
    .wdata(wdata),
    .re   (re_b),
    .raddr(raddr_b),
    .rdata(rdata_b)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (room) begin
      out_valid <= res.push;
    end
    if (res.push) begin
      status           <= res.status;
      term_exponent    <= res.exponent;
      term_coefficient <= res.coefficient;
      last             <= res.last;
    end
  end

endmodule
